// ===== rtl/assert_macros.svh =====
// assertion helpers for the rtl folder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/glob_pkg.sv =====
`timescale 1ns / 1ps

package glob_pkg;

    typedef enum logic [1:0] {
        OP_PAT_BYTE  = 2'd0,
        OP_PAT_END   = 2'd1,
        OP_TEXT_BYTE = 2'd2,
        OP_TEXT_END  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        KIND_LIT  = 2'd0,
        KIND_ANY  = 2'd1,
        KIND_STAR = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  lit;
    } t_elem;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

endpackage

// ===== rtl/glob_wildcard_matcher_top.sv =====
`timescale 1ns / 1ps
// Glob matcher: load a pattern with pattern-byte beats ('*' any run, '?' one byte,
// backslash escapes the next byte), optionally close it with a pattern-end beat, then
// stream text-byte beats and finish with a text-end beat. A new beat is accepted each cycle,
// but for the text-end hold-off below: the pattern store and the active-position vector
// (one bit per compiled element plus the start bit) are updated in a single registered
// pass. The text-end beat loads one result into the output register the following
// cycle and clears the job; a text-end beat is held off only while an earlier result
// is still stalled there. Patterns longer than MAX_PATTERN elements, or ending in a lone
// backslash, report pattern_error and never match.
`include "assert_macros.svh"

module glob_wildcard_matcher_top #(
    parameter int MAX_PATTERN = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_in_opcode,
    input  logic [7:0] i_in_data_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_matched,
    output logic       o_has_wildcard,
    output logic       o_pattern_error
);

    localparam int AW = MAX_PATTERN + 1;
    localparam int LW = $clog2(MAX_PATTERN + 1);

    glob_pkg::t_elem  r_elem [MAX_PATTERN];
    logic [LW-1:0]    r_len, n_len;
    logic [AW-1:0]    r_act, n_act;
    logic             r_esc, n_esc;
    logic             r_wild, n_wild;
    logic             r_bad, n_bad;
    logic             r_last_star, n_last_star;
    logic             r_out_valid, n_out_valid;
    logic             r_matched, r_has_wildcard, r_pattern_error;

    glob_pkg::t_opcode op;
    logic             in_acc;
    logic             out_take;
    logic             app_en;
    glob_pkg::t_elem  app_elem;
    logic             app_we;
    logic [LW-1:0]    len_a;
    logic             err;

    logic [MAX_PATTERN-1:0] lane_star;
    logic [MAX_PATTERN-1:0] lane_step;
    logic [AW-1:0]          txt_pre;
    logic [AW-1:0]          pre;
    logic [AW-1:0]          post;

    assign op         = glob_pkg::t_opcode'(i_in_opcode);
    assign out_take   = r_out_valid && !i_out_stall;
    assign o_in_stall = r_out_valid && i_out_stall && (op == glob_pkg::OP_TEXT_END);
    assign in_acc     = i_in_valid && !o_in_stall;

    // element append for pattern bytes
    always_comb begin
        app_en   = 1'b0;
        app_elem = '{kind: glob_pkg::KIND_LIT, lit: i_in_data_byte};
        n_esc    = r_esc;
        n_wild   = r_wild;
        if (in_acc && op == glob_pkg::OP_PAT_BYTE) begin
            if (r_esc) begin
                n_esc  = 1'b0;
                app_en = 1'b1;
            end else if (i_in_data_byte == glob_pkg::CH_BSLASH) begin
                n_esc = 1'b1;
            end else if (i_in_data_byte == glob_pkg::CH_STAR) begin
                n_wild   = 1'b1;
                app_elem = '{kind: glob_pkg::KIND_STAR, lit: 8'h00};
                app_en   = !r_last_star;
            end else if (i_in_data_byte == glob_pkg::CH_QMARK) begin
                n_wild   = 1'b1;
                app_elem = '{kind: glob_pkg::KIND_ANY, lit: 8'h00};
                app_en   = 1'b1;
            end else begin
                app_en = 1'b1;
            end
        end
    end

    assign app_we = app_en && (r_len != LW'(MAX_PATTERN));
    assign len_a  = app_we ? r_len + LW'(1) : r_len;

    // per-element lanes of the position automaton
    assign txt_pre[0] = 1'b0;
    assign post[0]    = pre[0];

    genvar gi;
    generate
        for (gi = 0; gi < MAX_PATTERN; gi++) begin : g_lane
            glob_pkg::t_elem e;
            logic            on;
            assign e  = (app_we && r_len == LW'(gi)) ? app_elem : r_elem[gi];
            assign on = LW'(gi) < len_a;
            assign lane_star[gi] = on && e.kind == glob_pkg::KIND_STAR;
            assign lane_step[gi] = on && (e.kind == glob_pkg::KIND_ANY ||
                                   (e.kind == glob_pkg::KIND_LIT && e.lit == i_in_data_byte));
            assign txt_pre[gi+1] = r_act[gi] && lane_step[gi];
            // star passage, one hop suffices since stars never sit side by side
            assign post[gi+1] = pre[gi+1] || (pre[gi] && lane_star[gi]);
        end
    endgenerate

    assign pre = (op == glob_pkg::OP_TEXT_BYTE)
               ? (txt_pre | ({1'b0, lane_star} & r_act))
               : r_act;

    assign err = r_bad || r_esc;

    always_comb begin
        n_len       = r_len;
        n_act       = r_act;
        n_bad       = r_bad;
        n_last_star = r_last_star;
        n_out_valid = r_out_valid && !out_take;
        if (in_acc) begin
            case (op)
                glob_pkg::OP_PAT_BYTE: begin
                    n_len = len_a;
                    n_act = post;
                    if (app_en && !app_we) begin
                        n_bad = 1'b1;
                    end
                    if (app_we) begin
                        n_last_star = app_elem.kind == glob_pkg::KIND_STAR;
                    end
                end
                glob_pkg::OP_PAT_END: begin
                    if (r_esc) begin
                        n_bad = 1'b1;
                    end
                end
                glob_pkg::OP_TEXT_BYTE: begin
                    n_act = post;
                end
                glob_pkg::OP_TEXT_END: begin
                    n_len       = '0;
                    n_act       = AW'(1);
                    n_bad       = 1'b0;
                    n_last_star = 1'b0;
                    n_out_valid = 1'b1;
                end
                default: begin
                    n_act = r_act;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_act       <= AW'(1);
            r_esc       <= 1'b0;
            r_wild      <= 1'b0;
            r_bad       <= 1'b0;
            r_last_star <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_act       <= n_act;
            r_esc       <= (in_acc && (op == glob_pkg::OP_PAT_END ||
                                       op == glob_pkg::OP_TEXT_END)) ? 1'b0 : n_esc;
            r_wild      <= (in_acc && op == glob_pkg::OP_TEXT_END) ? 1'b0 : n_wild;
            r_bad       <= n_bad;
            r_last_star <= n_last_star;
            r_out_valid <= n_out_valid;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (in_acc && op == glob_pkg::OP_TEXT_END) begin
            r_matched       <= !err && r_act[r_len];
            r_has_wildcard  <= r_wild;
            r_pattern_error <= err;
        end
    end

    // pattern store
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (app_we && r_len == LW'(i)) begin
                r_elem[i] <= app_elem;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_matched       = r_matched;
    assign o_has_wildcard  = r_has_wildcard;
    assign o_pattern_error = r_pattern_error;

    `ASSERT_NEXT(a_job_clears, i_clk, i_rst_n, in_acc && op == glob_pkg::OP_TEXT_END, r_len == '0 && r_act == AW'(1) && r_out_valid)
    `ASSERT_IMPLY(a_act_in_range, i_clk, i_rst_n, 1'b1, ((r_act >> r_len) >> 1) == '0)
    `ASSERT_IMPLY(a_last_star_len, i_clk, i_rst_n, r_last_star, r_len != '0)
    `ASSERT_IMPLY(a_no_match_on_err, i_clk, i_rst_n, r_out_valid && r_pattern_error, !r_matched)

endmodule
